// File: rtl/core/calendar_date_stepper_macros.svh
// Assertion macros of the date stepper RTL, used by cds_back.
// Needs nothing but a clock and a reset in the using module.
`ifndef CALENDAR_DATE_STEPPER_MACROS_SVH
`define CALENDAR_DATE_STEPPER_MACROS_SVH

// same-cycle implication
`define CDS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CDS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/cds_pkg.sv
// Types, constants and calendar helpers of the date stepper.
// Used by every other file of the block but the macros header; depends on nothing.
package cds_pkg;

   localparam int DAY_W    = 5;
   localparam int MONTH_W  = 4;
   localparam int YEAR_W   = 14;
   localparam int DELTA_W  = 16;
   localparam int STAT_W   = 2;
   localparam int WYEAR_W  = 16;   // signed year while stepping
   localparam int Q100_W   = 9;    // signed year / 100
   localparam int R100_W   = 7;    // year mod 100
   localparam int QUOT_W   = 8;    // unsigned quotient of a loaded year
   localparam int RECIP_W  = 13;
   localparam int PROD_W   = YEAR_W + RECIP_W;
   localparam int RECIP_SH = 19;
   localparam int CSR_IDX_W = 1;

   // floor(y / 100) = (y * 5243) >> 19, exact for any 14-bit y
   localparam logic [RECIP_W-1:0] DIV100_RECIP = 13'd5243;

   localparam logic [R100_W-1:0]  R100_TOP    = 7'd99;
   localparam logic [MONTH_W-1:0] MONTH_JAN   = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB   = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC   = 4'd12;
   localparam logic [DAY_W-1:0]   DAY_FIRST   = 5'd1;
   localparam logic [DAY_W-1:0]   DAY_DEC_END = 5'd31;

   localparam logic [YEAR_W-1:0]  YEAR_MIN_RESET = 14'd1902;
   localparam logic [YEAR_W-1:0]  YEAR_MAX_RESET = 14'd2037;
   localparam logic [YEAR_W-1:0]  CUR_YEAR_RESET = 14'd2000;
   localparam logic [Q100_W-1:0]  CUR_Q100_RESET = 9'd20;
   localparam logic [R100_W-1:0]  CUR_R100_RESET = 7'd0;

   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PTR_W = 1;
   localparam int FIFO_CNT_W = 2;

   typedef logic [DAY_W-1:0]          day_type;
   typedef logic [MONTH_W-1:0]        month_type;
   typedef logic [YEAR_W-1:0]         year_type;
   typedef logic signed [DELTA_W-1:0] delta_type;
   typedef logic [STAT_W-1:0]         stat_type;
   typedef logic [CSR_IDX_W-1:0]      csr_idx_type;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_ADD  = 1'b1
   } opcode_type;

   typedef enum logic [STAT_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_LOAD  = 2'd1,
      STATUS_BAD_RANGE = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_YEAR_MIN = 1'b0,
      CSR_YEAR_MAX = 1'b1
   } csr_reg_type;

   typedef enum logic [1:0] {
      FRONT_IDLE,
      FRONT_MUL,
      FRONT_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_STEP,
      BACK_CHECK,
      BACK_DONE
   } back_state_type;

   // one classified command, front to back
   typedef struct packed {
      opcode_type                opcode;
      logic                      load_ok;
      day_type                   day;
      month_type                 month;
      year_type                  year;
      logic signed [Q100_W-1:0]  q100;
      logic [R100_W-1:0]         r100;
      delta_type                 delta;
   } cmd_type;

   // Gregorian leap test from year mod 4, (year / 100) mod 4 and year mod 100
   function automatic logic is_leap(input logic [1:0] y_lo, input logic [1:0] q_lo,
                                    input logic [R100_W-1:0] r100);
      return (y_lo == 2'd0) && ((r100 != '0) || (q_lo == 2'd0));
   endfunction

   // month length; months outside 1..12 give a don't-care length
   function automatic day_type month_days(input month_type month, input logic leap);
      day_type len;
      case (month)
         MONTH_FEB:                    len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:      len = 5'd30;
         default:                      len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

// File: rtl/core/cds_if.sv
// Handshake channels of the date stepper: request, response, register write.
// Depends on cds_pkg for the payload types.
interface cds_req_if;
   logic                valid;
   logic                ready;
   logic                opcode;
   cds_pkg::day_type    day_in;
   cds_pkg::month_type  month_in;
   cds_pkg::year_type   year_in;
   cds_pkg::delta_type  day_delta;

   modport source (output valid, opcode, day_in, month_in, year_in, day_delta,
                   input ready);
   modport sink   (input valid, opcode, day_in, month_in, year_in, day_delta,
                   output ready);
endinterface

interface cds_rsp_if;
   logic                valid;
   logic                ready;
   cds_pkg::day_type    day_out;
   cds_pkg::month_type  month_out;
   cds_pkg::year_type   year_out;
   cds_pkg::stat_type   status;

   modport source (output valid, day_out, month_out, year_out, status, input ready);
   modport sink   (input valid, day_out, month_out, year_out, status, output ready);
endinterface

interface cds_csr_if;
   logic                  valid;
   logic                  ready;
   cds_pkg::csr_idx_type  index;
   cds_pkg::year_type     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/cds_front.sv
// Front end: takes a request, splits a loaded year by 100 and checks the date.
// Depends on cds_pkg and cds_if; feeds cds_fifo.
module cds_front (
   input  logic              clock,
   input  logic              reset,
   cds_req_if.sink           req_chan,
   input  cds_pkg::year_type year_min,
   input  cds_pkg::year_type year_max,
   output cds_pkg::cmd_type  push_data,
   output logic              push_valid,
   input  logic              push_ready
);
   import cds_pkg::*;

   front_state_type state_ff, state_in;

   opcode_type           opcode_ff;
   day_type              day_ff;
   month_type            month_ff;
   year_type             year_ff;
   delta_type            delta_ff;
   logic [QUOT_W-1:0]    quot_ff;

   logic                 accept;
   logic [PROD_W-1:0]    prod;
   logic [YEAR_W-1:0]    hund;
   logic [YEAR_W-1:0]    rem;
   logic [R100_W-1:0]    r100;
   logic                 leap;
   logic                 month_ok;
   logic                 year_ok;
   logic                 day_ok;

   assign accept = req_chan.valid && req_chan.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FRONT_IDLE: if (req_chan.valid) state_in = FRONT_MUL;
         FRONT_MUL:  state_in = FRONT_PUSH;
         FRONT_PUSH: if (push_ready) state_in = FRONT_IDLE;
         default:    state_in = FRONT_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_chan.ready = 1'b0;
      push_valid     = 1'b0;
      case (state_ff)
         FRONT_IDLE: req_chan.ready = 1'b1;
         FRONT_PUSH: push_valid     = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // captured request and quotient
   assign prod = PROD_W'(year_ff) * PROD_W'(DIV100_RECIP);

   always_ff @(posedge clock) begin
      if (accept) begin
         opcode_ff <= opcode_type'(req_chan.opcode);
         day_ff    <= req_chan.day_in;
         month_ff  <= req_chan.month_in;
         year_ff   <= req_chan.year_in;
         delta_ff  <= req_chan.day_delta;
      end
      if (state_ff == FRONT_MUL) begin
         quot_ff <= prod[RECIP_SH +: QUOT_W];
      end
   end

   // remainder, leap test and date check
   assign hund     = YEAR_W'(quot_ff) * YEAR_W'(100);
   assign rem      = year_ff - hund;
   assign r100     = rem[R100_W-1:0];
   assign leap     = is_leap(year_ff[1:0], quot_ff[1:0], r100);
   assign month_ok = (month_ff inside {[MONTH_JAN:MONTH_DEC]});
   assign year_ok  = (year_ff >= year_min) && (year_ff <= year_max);
   assign day_ok   = (day_ff != '0) && (day_ff <= month_days(month_ff, leap));

   always_comb begin
      push_data.opcode  = opcode_ff;
      push_data.load_ok = month_ok && year_ok && day_ok;
      push_data.day     = day_ff;
      push_data.month   = month_ff;
      push_data.year    = year_ff;
      push_data.q100    = Q100_W'(quot_ff);
      push_data.r100    = r100;
      push_data.delta   = delta_ff;
   end

endmodule

// File: rtl/core/cds_fifo.sv
// Two-entry command queue between front and back end.
// Depends on cds_pkg for the entry type.
module cds_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  cds_pkg::cmd_type push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output cds_pkg::cmd_type pop_data
);
   import cds_pkg::*;

   cmd_type                slot_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]  count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign push_ready = (count_ff != FIFO_CNT_W'(FIFO_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // pointers and fill count
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + FIFO_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + FIFO_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + FIFO_CNT_W'(1);
      if (do_pop && !do_push) count_in = count_ff - FIFO_CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/core/cds_back.sv
// Back end: holds the date, steps it one day per cycle, checks the result
// and drives the response register. Depends on cds_pkg, cds_if, macros.
module cds_back (
   input  logic              clock,
   input  logic              reset,
   input  cds_pkg::cmd_type  pop_data,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  cds_pkg::year_type year_min,
   input  cds_pkg::year_type year_max,
   cds_rsp_if.source         rsp_chan
);
   import cds_pkg::*;
   `include "calendar_date_stepper_macros.svh"

   back_state_type state_ff, state_in;

   // stored date with its split year
   day_type                    cur_day_ff,   cur_day_in;
   month_type                  cur_month_ff, cur_month_in;
   year_type                   cur_year_ff,  cur_year_in;
   logic signed [Q100_W-1:0]   cur_q100_ff,  cur_q100_in;
   logic [R100_W-1:0]          cur_r100_ff,  cur_r100_in;

   // date being stepped
   day_type                    work_day_ff,   work_day_in;
   month_type                  work_month_ff, work_month_in;
   logic signed [WYEAR_W-1:0]  work_year_ff,  work_year_in;
   logic signed [Q100_W-1:0]   work_q100_ff,  work_q100_in;
   logic [R100_W-1:0]          work_r100_ff,  work_r100_in;
   logic [DELTA_W-1:0]         remain_ff,     remain_in;
   logic                       back_ff,       back_in;

   status_type                 status_ff,     status_in;
   logic                       rsp_valid_ff,  rsp_valid_in;
   day_type                    rsp_day_ff;
   month_type                  rsp_month_ff;
   year_type                   rsp_year_ff;
   status_type                 rsp_status_ff;

   logic                       slot_free;
   logic                       emit;
   logic                       work_leap;
   day_type                    work_len;
   logic [DELTA_W-1:0]         delta_mag;
   logic                       range_ok;

   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign emit      = (state_ff == BACK_DONE) && slot_free;
   assign work_leap = is_leap(work_year_ff[1:0], work_q100_ff[1:0], work_r100_ff);
   assign work_len  = month_days(work_month_ff, work_leap);
   assign delta_mag = pop_data.delta[DELTA_W-1] ? (~pop_data.delta + DELTA_W'(1))
                                                : pop_data.delta;
   assign range_ok  = (work_year_ff >= $signed({2'b00, year_min}))
                   && (work_year_ff <= $signed({2'b00, year_max}));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (pop_valid) state_in = (pop_data.opcode == OP_ADD) ? BACK_STEP : BACK_DONE;
         end
         BACK_STEP:  if (remain_ff == '0) state_in = BACK_CHECK;
         BACK_CHECK: state_in = BACK_DONE;
         BACK_DONE:  if (slot_free) state_in = BACK_IDLE;
         default:    state_in = BACK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      pop_ready = 1'b0;
      case (state_ff)
         BACK_IDLE: pop_ready = 1'b1;
         default: ;
      endcase
   end

   // datapath next values
   always_comb begin
      cur_day_in    = cur_day_ff;
      cur_month_in  = cur_month_ff;
      cur_year_in   = cur_year_ff;
      cur_q100_in   = cur_q100_ff;
      cur_r100_in   = cur_r100_ff;
      work_day_in   = work_day_ff;
      work_month_in = work_month_ff;
      work_year_in  = work_year_ff;
      work_q100_in  = work_q100_ff;
      work_r100_in  = work_r100_ff;
      remain_in     = remain_ff;
      back_in       = back_ff;
      status_in     = status_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (pop_valid) begin
               work_day_in   = cur_day_ff;
               work_month_in = cur_month_ff;
               work_year_in  = WYEAR_W'(cur_year_ff);
               work_q100_in  = cur_q100_ff;
               work_r100_in  = cur_r100_ff;
               remain_in     = delta_mag;
               back_in       = pop_data.delta[DELTA_W-1];
               status_in     = STATUS_OK;
               if (pop_data.opcode == OP_LOAD) begin
                  if (pop_data.load_ok) begin
                     cur_day_in   = pop_data.day;
                     cur_month_in = pop_data.month;
                     cur_year_in  = pop_data.year;
                     cur_q100_in  = pop_data.q100;
                     cur_r100_in  = pop_data.r100;
                  end else begin
                     status_in = STATUS_BAD_LOAD;
                  end
               end
            end
         end
         BACK_STEP: begin
            if (remain_ff != '0) begin
               remain_in = remain_ff - DELTA_W'(1);
               if (!back_ff) begin
                  // one day forward
                  if (work_day_ff == work_len) begin
                     work_day_in = DAY_FIRST;
                     if (work_month_ff == MONTH_DEC) begin
                        work_month_in = MONTH_JAN;
                        work_year_in  = work_year_ff + WYEAR_W'(1);
                        if (work_r100_ff == R100_TOP) begin
                           work_r100_in = '0;
                           work_q100_in = work_q100_ff + Q100_W'(1);
                        end else begin
                           work_r100_in = work_r100_ff + R100_W'(1);
                        end
                     end else begin
                        work_month_in = work_month_ff + MONTH_W'(1);
                     end
                  end else begin
                     work_day_in = work_day_ff + DAY_W'(1);
                  end
               end else begin
                  // one day back
                  if (work_day_ff == DAY_FIRST) begin
                     if (work_month_ff == MONTH_JAN) begin
                        work_month_in = MONTH_DEC;
                        work_day_in   = DAY_DEC_END;
                        work_year_in  = work_year_ff - WYEAR_W'(1);
                        if (work_r100_ff == '0) begin
                           work_r100_in = R100_TOP;
                           work_q100_in = work_q100_ff - Q100_W'(1);
                        end else begin
                           work_r100_in = work_r100_ff - R100_W'(1);
                        end
                     end else begin
                        work_month_in = work_month_ff - MONTH_W'(1);
                        work_day_in   = month_days(work_month_ff - MONTH_W'(1), work_leap);
                     end
                  end else begin
                     work_day_in = work_day_ff - DAY_W'(1);
                  end
               end
            end
         end
         BACK_CHECK: begin
            // day and month are right by construction; only the year can fail
            if (range_ok) begin
               cur_day_in   = work_day_ff;
               cur_month_in = work_month_ff;
               cur_year_in  = work_year_ff[YEAR_W-1:0];
               cur_q100_in  = work_q100_ff;
               cur_r100_in  = work_r100_ff;
            end else begin
               status_in = STATUS_BAD_RANGE;
            end
         end
         default: ;
      endcase
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         rsp_valid_ff <= 1'b0;
         cur_day_ff   <= DAY_FIRST;
         cur_month_ff <= MONTH_JAN;
         cur_year_ff  <= CUR_YEAR_RESET;
         cur_q100_ff  <= CUR_Q100_RESET;
         cur_r100_ff  <= CUR_R100_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cur_day_ff   <= cur_day_in;
         cur_month_ff <= cur_month_in;
         cur_year_ff  <= cur_year_in;
         cur_q100_ff  <= cur_q100_in;
         cur_r100_ff  <= cur_r100_in;
      end
   end

   always_ff @(posedge clock) begin
      work_day_ff   <= work_day_in;
      work_month_ff <= work_month_in;
      work_year_ff  <= work_year_in;
      work_q100_ff  <= work_q100_in;
      work_r100_ff  <= work_r100_in;
      remain_ff     <= remain_in;
      back_ff       <= back_in;
      status_ff     <= status_in;
      if (emit) begin
         rsp_day_ff    <= cur_day_ff;
         rsp_month_ff  <= cur_month_ff;
         rsp_year_ff   <= cur_year_ff;
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.day_out   = rsp_day_ff;
   assign rsp_chan.month_out = rsp_month_ff;
   assign rsp_chan.year_out  = rsp_year_ff;
   assign rsp_chan.status    = rsp_status_ff;

   // checks
   `CDS_ASSERT_NEXT(a_step_count, clock, reset, (state_ff == BACK_STEP) && (remain_ff != '0), remain_ff == $past(remain_ff) - DELTA_W'(1), "step count did not fall by one")
   `CDS_ASSERT_IMPL(a_cur_month, clock, reset, 1'b1, (cur_month_ff >= MONTH_JAN) && (cur_month_ff <= MONTH_DEC), "stored month out of 1..12")
   `CDS_ASSERT_IMPL(a_work_day, clock, reset, state_ff == BACK_STEP, (work_day_ff != '0) && (work_day_ff <= work_len), "stepped day outside its month")
   `CDS_ASSERT_IMPL(a_work_r100, clock, reset, state_ff == BACK_STEP, work_r100_ff <= R100_TOP, "year remainder out of range")
   `CDS_ASSERT_NEXT(a_no_drop, clock, reset, rsp_valid_ff && !rsp_chan.ready, rsp_valid_ff && $stable(rsp_year_ff), "response dropped while stalled")

endmodule

// File: rtl/core/calendar_date_stepper.sv
// Top level of the date stepper: limit registers, front end, queue, back end.
// Depends on cds_pkg, cds_if, cds_front, cds_fifo and cds_back.
//
//   port       dir   carries
//   req_chan   in    opcode, day_in, month_in, year_in, day_delta
//   rsp_chan   out   day_out, month_out, year_out, status
//   csr_chan   in    index (0 year_min, 1 year_max), data
//
// An add steps the date |day_delta| days, one day at a time, in the
// back-end stepping loop. The front end takes the next request while the
// back end is busy, up to two queued commands. Reset is synchronous and
// restores 2000-01-01 and limits 1902..2037. A stalled response holds;
// the back end waits on it.
module calendar_date_stepper (
   input  logic    clock,
   input  logic    reset,
   cds_req_if.sink   req_chan,
   cds_rsp_if.source rsp_chan,
   cds_csr_if.sink   csr_chan
);
   import cds_pkg::*;

   year_type  year_min_ff, year_min_in;
   year_type  year_max_ff, year_max_in;
   cmd_type   push_data;
   logic      push_valid;
   logic      push_ready;
   cmd_type   pop_data;
   logic      pop_valid;
   logic      pop_ready;

   // limit registers
   assign csr_chan.ready = 1'b1;

   always_comb begin
      year_min_in = year_min_ff;
      year_max_in = year_max_ff;
      if (csr_chan.valid) begin
         case (csr_reg_type'(csr_chan.index))
            CSR_YEAR_MIN: year_min_in = csr_chan.data;
            CSR_YEAR_MAX: year_max_in = csr_chan.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         year_min_ff <= YEAR_MIN_RESET;
         year_max_ff <= YEAR_MAX_RESET;
      end else begin
         year_min_ff <= year_min_in;
         year_max_ff <= year_max_in;
      end
   end

   cds_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .year_min   (year_min_ff),
      .year_max   (year_max_ff),
      .push_data  (push_data),
      .push_valid (push_valid),
      .push_ready (push_ready)
   );

   cds_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   cds_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_data  (pop_data),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .year_min  (year_min_ff),
      .year_max  (year_max_ff),
      .rsp_chan  (rsp_chan)
   );

endmodule

// File: bench/testbench.sv
// Self-checking bench for calendar_date_stepper: directed and random requests
// against an in-bench calendar predictor. Needs cds_pkg, cds_if and the RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import cds_pkg::*;

   localparam int CYCLE_LIMIT = 20_000_000;
   localparam int TAIL_CYCLES = 40;
   localparam int PRINT_CAP   = 40;

   typedef struct {
      opcode_type op;
      day_type    day;
      month_type  month;
      year_type   year;
      delta_type  delta;
   } date_req_type;

   typedef struct {
      day_type    day;
      month_type  month;
      year_type   year;
      status_type status;
   } date_rsp_type;

   logic clock = 1'b0;
   logic reset;

   cds_req_if req_chan ();
   cds_rsp_if rsp_chan ();
   cds_csr_if csr_chan ();

   calendar_date_stepper uut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_chan(csr_chan)
   );

   // predicted calendar state and limits
   int cal_day   = 1;
   int cal_month = 1;
   int cal_year  = 2000;
   int lim_min   = 1902;
   int lim_max   = 2037;

   date_req_type queued_cmds[$];
   date_rsp_type expected_dates[$];
   date_req_type sent_cmd;
   int        send_gap    = 0;
   int        recv_stall  = 0;
   bit        send_idling = 1'b1;
   bit        recv_idling = 1'b1;
   int        mismatches  = 0;
   int        cycle_count = 0;

   always #1 clock = ~clock;

   // proleptic Gregorian month length, any signed year
   function automatic int days_of_month(int m, int y);
      bit leap;
      leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
      case (m)
         2:           return leap ? 29 : 28;
         4, 6, 9, 11: return 30;
         default:     return 31;
      endcase
   endfunction

   function automatic bit date_valid(int d, int m, int y);
      if (m < 1 || m > 12) return 1'b0;
      if (y < lim_min || y > lim_max) return 1'b0;
      return (d >= 1) && (d <= days_of_month(m, y));
   endfunction

   // apply one request to the predicted date and return the expected response
   function automatic date_rsp_type predict_date(date_req_type c);
      date_rsp_type r;
      int d, m, y, n;
      r.status = STATUS_OK;
      if (c.op == OP_LOAD) begin
         d = int'(c.day);
         m = int'(c.month);
         y = int'(c.year);
         if (!date_valid(d, m, y)) r.status = STATUS_BAD_LOAD;
      end else begin
         d = cal_day;
         m = cal_month;
         y = cal_year;
         n = int'(c.delta);
         // walk forward or backward, one day per step
         while (n > 0) begin
            d++;
            if (d > days_of_month(m, y)) begin
               d = 1;
               if (m == 12) begin
                  m = 1;
                  y++;
               end else m++;
            end
            n--;
         end
         while (n < 0) begin
            d--;
            if (d < 1) begin
               if (m == 1) begin
                  m = 12;
                  y--;
               end else m--;
               d = days_of_month(m, y);
            end
            n++;
         end
         if (!date_valid(d, m, y)) r.status = STATUS_BAD_RANGE;
      end
      if (r.status == STATUS_OK) begin
         cal_day   = d;
         cal_month = m;
         cal_year  = y;
      end
      r.day   = day_type'(cal_day);
      r.month = month_type'(cal_month);
      r.year  = year_type'(cal_year);
      return r;
   endfunction

   task automatic flag_mismatch(string what, int got, int want);
      mismatches++;
      if (mismatches <= PRINT_CAP)
         $display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
   endtask

   task automatic queue_load(int d, int m, int y);
      date_req_type c;
      c.op    = OP_LOAD;
      c.day   = day_type'(d);
      c.month = month_type'(m);
      c.year  = year_type'(y);
      c.delta = delta_type'($urandom);
      queued_cmds.push_back(c);
   endtask

   task automatic queue_add(int n);
      date_req_type c;
      c.op    = OP_ADD;
      c.day   = day_type'($urandom);
      c.month = month_type'($urandom);
      c.year  = year_type'($urandom);
      c.delta = delta_type'(n);
      queued_cmds.push_back(c);
   endtask

   // wait, sampling at the falling edge, until nothing is queued or in flight
   task automatic drain_requests();
      do @(negedge clock);
      while (queued_cmds.size() > 0 || req_chan.valid || expected_dates.size() > 0);
   endtask

   // limit register write; only called with the block idle
   task automatic write_limit(csr_reg_type idx, year_type value);
      @(posedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      do @(posedge clock);
      while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      if (idx == CSR_YEAR_MIN) lim_min = int'(value);
      else lim_max = int'(value);
      @(negedge clock);
   endtask

   // request driver: predicts on acceptance, then offers the next request
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            expected_dates.push_back(predict_date(sent_cmd));
         if (!req_chan.valid || req_chan.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_chan.valid <= 1'b0;
            end else if (queued_cmds.size() > 0) begin
               sent_cmd = queued_cmds.pop_front();
               req_chan.valid     <= 1'b1;
               req_chan.opcode    <= sent_cmd.op;
               req_chan.day_in    <= sent_cmd.day;
               req_chan.month_in  <= sent_cmd.month;
               req_chan.year_in   <= sent_cmd.year;
               req_chan.day_delta <= sent_cmd.delta;
               if (send_idling && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 6);
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor with random stall bursts
   always @(posedge clock) begin
      date_rsp_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_dates.size() == 0) begin
               flag_mismatch("response with no request waiting", rsp_chan.status, -1);
            end else begin
               want = expected_dates.pop_front();
               if (rsp_chan.day_out !== want.day)
                  flag_mismatch("day_out", rsp_chan.day_out, want.day);
               if (rsp_chan.month_out !== want.month)
                  flag_mismatch("month_out", rsp_chan.month_out, want.month);
               if (rsp_chan.year_out !== want.year)
                  flag_mismatch("year_out", rsp_chan.year_out, want.year);
               if (rsp_chan.status !== want.status)
                  flag_mismatch("status", rsp_chan.status, want.status);
            end
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_chan.ready <= 1'b0;
         end else if (recv_idling && $urandom_range(0, 4) == 0) begin
            recv_stall = $urandom_range(0, 5);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      int y, m, d, lo, hi;
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.opcode    = OP_LOAD;
      req_chan.day_in    = '0;
      req_chan.month_in  = '0;
      req_chan.year_in   = '0;
      req_chan.day_delta = '0;
      rsp_chan.ready     = 1'b0;
      csr_chan.valid     = 1'b0;
      csr_chan.index     = CSR_YEAR_MIN;
      csr_chan.data      = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset limits: every rejection reason and the limit edges
      queue_add(0);
      queue_load(29, 2, 2000);
      queue_load(29, 2, 2001);
      queue_load(0, 5, 2000);
      queue_load(1, 0, 2000);
      queue_load(1, 13, 2000);
      queue_load(31, 15, 16383);
      queue_load(31, 12, 2037);
      queue_add(1);
      queue_load(1, 1, 1902);
      queue_add(-1);
      queue_add(32767);
      queue_add(-32768);
      drain_requests();

      // widest limits: century rules, year zero, years past 9999
      write_limit(CSR_YEAR_MIN, 14'd0);
      write_limit(CSR_YEAR_MAX, 14'h3FFF);
      queue_load(28, 2, 1900);
      queue_add(1);
      queue_load(28, 2, 2400);
      queue_add(1);
      queue_load(1, 1, 0);
      queue_add(-32768);
      queue_load(29, 2, 12000);
      queue_add(32767);
      queue_load(15, 6, 2020);
      drain_requests();

      // crossed limits accept nothing
      write_limit(CSR_YEAR_MIN, 14'd3000);
      write_limit(CSR_YEAR_MAX, 14'd1000);
      queue_load(1, 1, 2000);
      queue_add(0);
      drain_requests();

      // limits moved away from the stored date
      write_limit(CSR_YEAR_MIN, 14'd2100);
      write_limit(CSR_YEAR_MAX, 14'd2200);
      queue_add(0);
      queue_add(30000);
      drain_requests();

      // random phases; the third and the last run without idling
      for (int p = 0; p < 5; p++) begin
         if (p == 4) begin
            lo = 0;
            hi = 16383;
         end else if (p == 1) begin
            lo = $urandom_range(0, 16383);
            hi = $urandom_range(0, 16383);
         end else begin
            lo = $urandom_range(1583, 1990);
            hi = lo + $urandom_range(20, 200);
         end
         send_idling = (p != 2) && (p != 4);
         recv_idling = send_idling;
         write_limit(CSR_YEAR_MIN, year_type'(lo));
         write_limit(CSR_YEAR_MAX, year_type'(hi));
         for (int i = 0; i < 15; i++) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: begin
                  if (lo <= hi) begin
                     y = $urandom_range(lo, hi);
                     if ($urandom_range(0, 3) == 0) y = $urandom_range(0, 1) ? lo : hi;
                     m = $urandom_range(1, 12);
                     d = $urandom_range(1, days_of_month(m, y));
                     if ($urandom_range(0, 2) == 0) d = days_of_month(m, y);
                     queue_load(d, m, y);
                  end else begin
                     queue_load($urandom, $urandom, $urandom);
                  end
               end
               4: queue_load($urandom, $urandom, $urandom);
               default: begin
                  if ($urandom_range(0, 9) == 0) queue_add($urandom);
                  else queue_add(int'($urandom_range(0, 1600)) - 800);
               end
            endcase
         end
         drain_requests();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/cds_pkg.sv
rtl/core/cds_if.sv
rtl/core/cds_front.sv
rtl/core/cds_fifo.sv
rtl/core/cds_back.sv
rtl/core/calendar_date_stepper.sv
bench/testbench.sv
